/* hdl/isort_pkg.sv */
// isort_pkg: payload and control types for the insertion sorter.
// No dependencies; used by isort_cell and insertion_sorter.
package isort_pkg;

	typedef struct packed {
		logic signed [31:0] key;
		logic               last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sorted_key;
		logic               final_res;
		logic               dropped;
	} out_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;  // insert the new key
		logic shl;  // shift whole chain toward cell 0
	} cell_ctl_t;

endpackage

/* hdl/insertion_sorter.sv */
// insertion_sorter: top level, systolic ascending insertion sorter.
// Depends on isort_pkg and isort_cell.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes one signed key per
//    transfer. Every cell compares it against its own key in parallel, so
//    a key is registered in its slot and the next may follow directly.
//  - A key with last set closes the set. The chain then drains one key
//    per cycle from cell 0 into the output register, smallest first, when
//    that register is free or being emptied. in_ready stays low for the
//    whole drain.
//  - Output channel (out_valid/out_ready/out_data) carries sorted_key,
//    final_res on the last key of the run, and dropped when some key of
//    the set found the chain full (DEPTH keys) and was discarded.
//  - The last key sets the drain state; the drain then loads the first result.
//  - Receiver stall: the output register holds, the chain holds its
//    keys, nothing is lost.
//  - Reset: count, overflow flag and output valid clear; the chain's key
//    registers are not reset since only occupied cells are ever read.
module insertion_sorter #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  isort_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output isort_pkg::out_t   out_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	// state codes
	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                        state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        ovf_q;
	logic                        out_valid_q;
	isort_pkg::out_t             out_q;

	logic                        in_xfer;
	logic                        full;
	logic                        load;
	isort_pkg::cell_ctl_t        ctl;
	logic signed [KEY_WIDTH-1:0] new_key;

	logic signed [KEY_WIDTH-1:0] key_w [DEPTH];
	logic                        gt_w  [DEPTH];

	// input key taken as KEY_WIDTH-bit two's complement
	assign new_key  = KEY_WIDTH'(in_data.key);
	assign in_ready = state_q == ST_FILL;
	assign in_xfer  = in_valid && in_ready;
	assign full     = cnt_q == DEPTH_C;

	// drain step: output register free or being emptied this cycle
	assign load = (state_q == ST_DRAIN) && (!out_valid_q || out_ready);

	assign ctl.ins = in_xfer && !full;
	assign ctl.shl = load;

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_WIDTH-1:0] lk;
		logic                        lg;
		logic signed [KEY_WIDTH-1:0] rk;
		if (i == 0) begin : g_first
			assign lk = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lk = key_w[i-1];
			assign lg = gt_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rk = '0;
		end else begin : g_inner
			assign rk = key_w[i+1];
		end
		isort_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cnt       (cnt_q),
			.new_key   (new_key),
			.left_key  (lk),
			.left_gt   (lg),
			.right_key (rk),
			.key       (key_w[i]),
			.gt        (gt_w[i])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a drain step refills the output register, else a transfer empties it
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (in_xfer) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + ONE_C;
						end
						if (in_data.last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (load) begin
						cnt_q <= cnt_q - ONE_C;
						if (cnt_q == ONE_C) begin
							state_q <= ST_FILL;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.sorted_key <= 32'(key_w[0]);
			out_q.final_res  <= cnt_q == ONE_C;
			out_q.dropped    <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/isort_cell.sv */
// isort_cell: one slot of the sorting chain, holds a single key.
// Depends on isort_pkg.
module isort_cell #(
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 7,
	parameter int IDX       = 0
) (
	input  logic                        clk,
	input  isort_pkg::cell_ctl_t        ctl,
	input  logic [CNT_W-1:0]            cnt,
	input  logic signed [KEY_WIDTH-1:0] new_key,
	input  logic signed [KEY_WIDTH-1:0] left_key,
	input  logic                        left_gt,
	input  logic signed [KEY_WIDTH-1:0] right_key,
	output logic signed [KEY_WIDTH-1:0] key,
	output logic                        gt
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [KEY_WIDTH-1:0] key_q;
	logic                        occ;

	assign occ = IDX_C < cnt;
	// strictly greater: equal keys stay ahead of the newcomer
	assign gt  = occ && (key_q > new_key);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			key_q <= right_key;
		end else if (ctl.ins) begin
			if (left_gt) begin
				key_q <= left_key;
			end else if (gt || IDX_C == cnt) begin
				key_q <= new_key;
			end
		end
	end

endmodule
